### src/chunk_file_name_parser_macros.svh
// assertion macros for the chunk file name parser
// included by files that carry concurrent checks; no other dependencies
`ifndef CHUNK_FILE_NAME_PARSER_MACROS_SVH
`define CHUNK_FILE_NAME_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, gated by the async reset
`define CFNP_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("cfnp check failed");

// next-cycle implication, gated by the async reset
`define CFNP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("cfnp check failed");

`else

`define CFNP_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define CFNP_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

### src/cfnp_pkg.sv
// shared types, character constants and helpers of the chunk file name parser
// no dependencies
`timescale 1ns / 1ps

package cfnp_pkg;

	localparam logic [7:0] ChC     = 8'h63;
	localparam logic [7:0] ChDot   = 8'h2e;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChD     = 8'h64;
	localparam logic [7:0] ChA     = 8'h61;
	localparam logic [7:0] ChT     = 8'h74;

	// running magnitude may reach 2^31 but never exceed it
	localparam logic [37:0] MagLimit = 38'h00_8000_0000;

	localparam logic [2:0] CountMax   = 3'd7;
	localparam logic [2:0] BodyStart  = 3'd6;

	typedef enum logic [1:0] {
		PH_PREFIX_C,
		PH_PREFIX_DOT,
		PH_FIELD_X,
		PH_FIELD_Z
	} phase_t;

	typedef struct packed {
		logic        negative;
		logic        has_digit;
		logic        at_start;
		logic [31:0] magnitude;
	} field_t;

	localparam field_t FieldClear = '{
		negative:  1'b0,
		has_digit: 1'b0,
		at_start:  1'b1,
		magnitude: 32'd0
	};

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} digit_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] value;
	} finish_t;

	function automatic digit_t digit_decode(logic [7:0] c);
		digit_t     d;
		logic [7:0] diff;
		d    = '0;
		diff = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			diff = c - 8'h30;
			d.valid = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			diff = c - 8'h57;
			d.valid = 1'b1;
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			diff = c - 8'h37;
			d.valid = 1'b1;
		end
		d.value = diff[5:0];
		return d;
	endfunction

	// magnitude never exceeds 2^31, so bit 31 set means exactly 2^31
	function automatic finish_t field_finish(field_t f);
		finish_t r;
		r.ok    = f.has_digit && (f.negative || !f.magnitude[31]);
		r.value = f.negative ? (32'd0 - f.magnitude) : f.magnitude;
		return r;
	endfunction

endpackage

### src/cfnp_if.sv
// stream interfaces of the chunk file name parser: character input and result output
// depends on nothing but the language
`timescale 1ns / 1ps

interface cfnp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cfnp_result_if;
	logic               valid;
	logic               ready;
	logic               name_ok;
	logic signed [31:0] chunk_x;
	logic signed [31:0] chunk_z;

	modport source (output valid, output name_ok, output chunk_x, output chunk_z, input ready);
	modport sink   (input valid, input name_ok, input chunk_x, input chunk_z, output ready);
endinterface

### src/cfnp_field_step.sv
// one character step of a signed base36 field: sign, digit decode, multiply by 36 and add
// depends on cfnp_pkg
`timescale 1ns / 1ps

module cfnp_field_step
	import cfnp_pkg::*;
(
	input  logic [7:0] char_code,
	input  field_t     cur,
	output field_t     nxt,
	output logic       fail
);

	digit_t      dig;
	logic [37:0] wide;
	logic [37:0] sum;

	assign dig  = digit_decode(char_code);
	assign wide = {6'd0, cur.magnitude};
	// times 36 as (m << 5) + (m << 2)
	assign sum  = (wide << 5) + (wide << 2) + {32'd0, dig.value};

	always_comb begin
		nxt  = cur;
		fail = 1'b0;
		if (cur.at_start && char_code == ChMinus) begin
			nxt.negative = 1'b1;
			nxt.at_start = 1'b0;
		end else begin
			nxt.at_start = 1'b0;
			if (!dig.valid) begin
				fail = 1'b1;
			end else if (sum > MagLimit) begin
				fail = 1'b1;
			end else begin
				nxt.magnitude = sum[31:0];
				nxt.has_digit = 1'b1;
			end
		end
	end

endmodule

### src/chunk_file_name_parser.sv
// chunk file name parser top level: input register, parse state, result register
// depends on cfnp_pkg, cfnp_if, cfnp_field_step and the assertion macro header
//
// usage:
//   in_chars carries one byte of a file name per request (char_code), with
//   last_char set on the final byte. results carries one request per name:
//   name_ok, and chunk_x / chunk_z when the name has the form c.X.Z.dat,
//   X and Z signed base36 values in the 32-bit range; both are zero when
//   the name is rejected.
//   throughput: one character per cycle, except while a final character
//   waits on a held result. the final character is taken into the input
//   register, then the parse step writes the result register from it.
//   the last four bytes sit in a delay window, so body bytes are parsed four
//   characters late; the suffix check reads the window on the final byte.
//   a stall on results blocks only when a second final character reaches the
//   input register while the previous result is still held; other characters
//   keep flowing into the parse state.
//   reset clears the parse state and both valid flags; after each final
//   character the parse state returns to its reset value for the next name.
`timescale 1ns / 1ps
`include "chunk_file_name_parser_macros.svh"

module chunk_file_name_parser
	import cfnp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	cfnp_char_if.sink            in_chars,
	cfnp_result_if.source        results
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// parse state
	logic [2:0] count_q;
	phase_t     phase_q;
	logic       failed_q;
	field_t     field_q;
	logic [31:0] first_q;
	logic [7:0] win_q [4];

	// result register
	logic               out_valid_q;
	logic               name_ok_q;
	logic signed [31:0] chunk_x_q;
	logic signed [31:0] chunk_z_q;

	logic       advance;
	logic       in_ready;

	logic [2:0] count_n;
	phase_t     phase_n;
	logic       failed_n;
	field_t     field_n;
	logic [31:0] first_n;
	logic [7:0] win_n [4];

	field_t     step_nxt;
	logic       step_fail;
	finish_t    x_fin;
	finish_t    z_fin;
	logic       suffix_ok;
	logic       name_ok_n;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || results.ready);
	assign in_ready = !valid_s1 || advance;
	assign in_chars.ready = in_ready;

	cfnp_field_step u_field_step (
		.char_code (win_q[0]),
		.cur       (field_q),
		.nxt       (step_nxt),
		.fail      (step_fail)
	);

	assign x_fin = field_finish(field_q);

	always_comb begin
		phase_n  = phase_q;
		failed_n = failed_q;
		field_n  = field_q;
		first_n  = first_q;
		win_n    = win_q;
		if (count_q == 3'd0) begin
			if (char_s1 != ChC) failed_n = 1'b1;
			phase_n = PH_PREFIX_DOT;
		end else if (count_q == 3'd1) begin
			if (char_s1 != ChDot) failed_n = 1'b1;
			phase_n = PH_FIELD_X;
		end else begin
			// oldest window byte is a body byte once six bytes have been seen
			if (count_q >= BodyStart && !failed_q) begin
				unique case (phase_q)
					PH_FIELD_X: begin
						if (win_q[0] == ChDot) begin
							if (!x_fin.ok) begin
								failed_n = 1'b1;
							end else begin
								first_n = x_fin.value;
								field_n = FieldClear;
								phase_n = PH_FIELD_Z;
							end
						end else begin
							field_n = step_nxt;
							if (step_fail) failed_n = 1'b1;
						end
					end
					PH_FIELD_Z: begin
						field_n = step_nxt;
						if (step_fail) failed_n = 1'b1;
					end
					PH_PREFIX_C, PH_PREFIX_DOT: begin
						failed_n = 1'b1;
					end
				endcase
			end
			win_n[0] = win_q[1];
			win_n[1] = win_q[2];
			win_n[2] = win_q[3];
			win_n[3] = char_s1;
		end
		count_n = (count_q == CountMax) ? CountMax : count_q + 3'd1;
	end

	assign z_fin     = field_finish(field_n);
	assign suffix_ok = win_n[0] == ChDot && win_n[1] == ChD &&
	                   win_n[2] == ChA && win_n[3] == ChT;
	assign name_ok_n = !failed_n && count_q >= BodyStart && phase_n == PH_FIELD_Z &&
	                   suffix_ok && z_fin.ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_chars.valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_chars.valid && in_ready) begin
			char_s1 <= in_chars.char_code;
			last_s1 <= in_chars.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			phase_q  <= PH_PREFIX_C;
			failed_q <= 1'b0;
			field_q  <= FieldClear;
			first_q  <= '0;
			win_q    <= '{default: 8'd0};
		end else if (advance) begin
			if (last_s1) begin
				count_q  <= '0;
				phase_q  <= PH_PREFIX_C;
				failed_q <= 1'b0;
				field_q  <= FieldClear;
				first_q  <= '0;
				win_q    <= '{default: 8'd0};
			end else begin
				count_q  <= count_n;
				phase_q  <= phase_n;
				failed_q <= failed_n;
				field_q  <= field_n;
				first_q  <= first_n;
				win_q    <= win_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			name_ok_q <= name_ok_n;
			chunk_x_q <= name_ok_n ? first_n : 32'd0;
			chunk_z_q <= name_ok_n ? z_fin.value : 32'd0;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.name_ok = name_ok_q;
	assign results.chunk_x = chunk_x_q;
	assign results.chunk_z = chunk_z_q;

	// a rejected name never carries coordinates
	`CFNP_ASSERT_IMPL(a_reject_zero, clk, arst_n,
		out_valid_q && !name_ok_q, chunk_x_q == 32'sd0 && chunk_z_q == 32'sd0)

	// the final character leaves the parse state cleared for the next name
	`CFNP_ASSERT_NEXT(a_clear_after_last, clk, arst_n,
		advance && last_s1, count_q == 3'd0 && !failed_q && phase_q == PH_PREFIX_C)

	// input only stalls behind a final character waiting on a held result
	`CFNP_ASSERT_IMPL(a_stall_cause, clk, arst_n,
		!in_ready, valid_s1 && last_s1 && out_valid_q && !results.ready)

endmodule
